// ----- src/line_to_line_distance_3d_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef LINE_TO_LINE_DISTANCE_3D_UNIT_MACROS_SVH
`define LINE_TO_LINE_DISTANCE_3D_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LLD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LLD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lld_pkg.sv -----
// Shared constants and types for the 3D line distance unit.
`default_nettype none
package lld_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int TOL_W           = 16;
  localparam int TOL_RESET       = 16;
  localparam int NORM_TOP        = 30;
  localparam int SV_W            = NORM_TOP + 1;
  localparam int SQ_W            = 2 * SV_W;
  localparam int LEN_W           = NORM_TOP + 1;
  localparam int EXP_W           = 8;
  localparam int DIV_W           = 64;
  localparam int SHIFT_LIM       = 32;

  typedef enum logic [1:0] {
    MODE_DIV,
    MODE_ZERO,
    MODE_SAT
  } lld_mode_e;

  typedef struct packed {
    lld_mode_e mode;
    logic      neg;
    logic      par;
  } lld_ctl_t;
endpackage
`default_nettype wire

// ----- src/lld_scale.sv -----
// Three-stage block scaler: max magnitude, leading one, shift to NORM_TOP bits.
`default_nettype none
module lld_scale import lld_pkg::*; #(
  parameter int IN_W = 49
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [IN_W-1:0]  c_i [3],
  output logic signed [SV_W-1:0]  o_o [3],
  output logic signed [EXP_W-1:0] e_o
);
  localparam int CNT_W = $clog2(IN_W + 1);
  localparam int EXT_W = (IN_W > SV_W) ? IN_W : SV_W;

  logic signed [IN_W-1:0]  c1_q [3];
  logic signed [IN_W-1:0]  c2_q [3];
  logic [IN_W-1:0]         mag_d [3];
  logic [IN_W-1:0]         max_d, max_q;
  logic [CNT_W-1:0]        bits_d, bits_q;
  logic signed [SV_W-1:0]  o_d [3], o_q [3];
  logic signed [EXP_W-1:0] e_d, e_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = c_i[i][IN_W-1] ? IN_W'(-c_i[i]) : IN_W'(c_i[i]);
    end
    max_d = mag_d[0];
    if (mag_d[1] > max_d) max_d = mag_d[1];
    if (mag_d[2] > max_d) max_d = mag_d[2];
  end

  always_comb begin
    bits_d = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (max_q[i]) bits_d = CNT_W'(i + 1);
    end
  end

  always_comb begin
    int                     nb;
    logic signed [EXT_W-1:0] ext;
    nb  = int'(bits_q);
    e_d = '0;
    for (int i = 0; i < 3; i++) begin
      ext = EXT_W'(c2_q[i]);
      if (nb == 0) begin
        o_d[i] = '0;
      end else if (nb > NORM_TOP) begin
        o_d[i] = SV_W'(ext >>> (nb - NORM_TOP));
      end else begin
        o_d[i] = SV_W'(ext <<< (NORM_TOP - nb));
      end
    end
    if (nb != 0) e_d = EXP_W'(NORM_TOP - nb);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q   <= c_i;
      max_q  <= max_d;
      c2_q   <= c1_q;
      bits_q <= bits_d;
      o_q    <= o_d;
      e_q    <= e_d;
    end
  end

  assign o_o = o_q;
  assign e_o = e_q;
endmodule
`default_nettype wire

// ----- src/lld_isqrt.sv -----
// Two-lane pipelined floor square root, one root bit per stage.
`default_nettype none
module lld_isqrt import lld_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   x_i [2],
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [LEN_W-1:0]  root_o [2],
  output logic [SIDE_W-1:0] side_o
);
  logic                v_q    [LEN_W+1];
  logic [SQ_W:0]       rem_q  [LEN_W+1][2];
  logic [LEN_W-1:0]    root_q [LEN_W+1][2];
  logic [SIDE_W-1:0]   side_q [LEN_W+1];
  logic [SQ_W:0]       rem_d  [LEN_W][2];
  logic [LEN_W-1:0]    root_d [LEN_W][2];

  always_comb begin
    int            b;
    logic [SQ_W:0] t;
    for (int s = 0; s < LEN_W; s++) begin
      b = LEN_W - 1 - s;
      for (int l = 0; l < 2; l++) begin
        t = ((SQ_W+1)'(root_q[s][l]) << (b + 1)) | ((SQ_W+1)'(1) << (2 * b));
        if (rem_q[s][l] >= t) begin
          rem_d[s][l]  = rem_q[s][l] - t;
          root_d[s][l] = root_q[s][l] | (LEN_W'(1) << b);
        end else begin
          rem_d[s][l]  = rem_q[s][l];
          root_d[s][l] = root_q[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= LEN_W; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 0; s < LEN_W; s++) v_q[s+1] <= v_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l]  <= {1'b0, x_i[l]};
        root_q[0][l] <= '0;
      end
      side_q[0] <= side_i;
      for (int s = 0; s < LEN_W; s++) begin
        rem_q[s+1]  <= rem_d[s];
        root_q[s+1] <= root_d[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = v_q[LEN_W];
  assign root_o  = root_q[LEN_W];
  assign side_o  = side_q[LEN_W];
endmodule
`default_nettype wire

// ----- src/lld_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with range check.
`default_nettype none
module lld_div import lld_pkg::*; #(
  parameter int QW     = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DIV_W-1:0]  num_i,
  input  logic [DIV_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QW-1:0]     quo_o,
  output logic              ovf_o,
  output logic [SIDE_W-1:0] side_o
);
  logic              v_q    [QW+1];
  logic [DIV_W-1:0]  rem_q  [QW+1];
  logic [QW-1:0]     lq_q   [QW+1];
  logic [DIV_W-1:0]  den_q  [QW+1];
  logic [SIDE_W-1:0] side_q [QW+1];
  logic              ovf_q  [QW];
  logic [DIV_W-1:0]  rem_d  [QW];
  logic [QW-1:0]     lq_d   [QW];

  always_comb begin
    logic [DIV_W-1:0] r;
    logic             ge;
    for (int s = 0; s < QW; s++) begin
      r        = {rem_q[s][DIV_W-2:0], lq_q[s][QW-1]};
      ge       = (r >= den_q[s]);
      rem_d[s] = ge ? (r - den_q[s]) : r;
      lq_d[s]  = {lq_q[s][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= QW; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 0; s < QW; s++) v_q[s+1] <= v_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i >> QW;
      lq_q[0]   <= num_i[QW-1:0];
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      ovf_q[0]  <= (rem_q[0] >= den_q[0]);
      for (int s = 0; s < QW; s++) begin
        rem_q[s+1]  <= rem_d[s];
        lq_q[s+1]   <= lq_d[s];
        den_q[s+1]  <= den_q[s];
        side_q[s+1] <= side_q[s];
      end
      for (int s = 0; s < QW - 1; s++) ovf_q[s+1] <= ovf_q[s];
    end
  end

  assign valid_o = v_q[QW];
  assign quo_o   = lq_q[QW];
  assign ovf_o   = ovf_q[QW-1];
  assign side_o  = side_q[QW];
endmodule
`default_nettype wire

// ----- src/line_to_line_distance_3d_unit.sv -----
// Top level of the 3D line-to-line distance unit.
// Takes one word per cycle while the output is not stalled. Data passes through the
// cross products, block scaling, squares and dot products, the square-root pipeline,
// the divider pipeline and one output register. Results leave in input order; a stalled
// output freezes the whole pipeline. COORD_WIDTH is supported from 16 to 32, FRAC_BITS
// from 8 to 24. The user must write the tolerance register only while the unit is idle;
// the unit itself does not enforce this.
`default_nettype none
module line_to_line_distance_3d_unit import lld_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [TOL_W-1:0]              cfg_near_zero_tolerance_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] dir_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_b_z_i,
  input  logic signed [COORD_WIDTH-1:0] joint_x_i,
  input  logic signed [COORD_WIDTH-1:0] joint_y_i,
  input  logic signed [COORD_WIDTH-1:0] joint_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0] distance_o,
  output logic                          lines_parallel_o,
  output logic                          fault_o
);
  localparam int CW     = COORD_WIDTH;
  localparam int PROD_W = 2 * CW;
  localparam int XW     = PROD_W + 1 - FRAC_BITS;
  localparam int CMP_W  = (XW + 1 > TOL_W) ? XW + 1 : TOL_W;
  localparam int DPW    = CW + SV_W;
  localparam int DOT_W  = DPW + 2;
  localparam int SIDE_W = DOT_W + EXP_W + 1;
  localparam int CTL_W  = $bits(lld_ctl_t);
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [XW-1:0] cross_snap(
    input logic signed [PROD_W-1:0] x,
    input logic signed [PROD_W-1:0] y,
    input logic [TOL_W-1:0]         tol
  );
    logic signed [PROD_W:0] diff;
    logic signed [XW-1:0]   d;
    logic [XW-1:0]          mg;
    diff = (PROD_W+1)'(x) - (PROD_W+1)'(y);
    d    = XW'(diff >>> FRAC_BITS);
    mg   = d[XW-1] ? XW'(-d) : XW'(d);
    if (CMP_W'(mg) <= CMP_W'(tol)) d = '0;
    return d;
  endfunction

  logic              en;
  logic [TOL_W-1:0]  tol_q;

  logic                     v1_q;
  logic signed [PROD_W-1:0] pn_q [6];
  logic signed [PROD_W-1:0] pm_q [6];
  logic signed [CW-1:0]     a_d [3], b_d [3], w_d [3];
  logic signed [CW-1:0]     b1_q [3], w1_q [3];

  logic                 v2_q;
  logic signed [XW-1:0] n2_q [3], m2_q [3];
  logic signed [CW-1:0] b2_q [3], w2_q [3];
  logic                 par_d;

  logic                 v_sc_q   [3];
  logic                 par_sc_q [3];
  logic signed [CW-1:0] w_sc_q   [3][3];
  logic signed [SV_W-1:0]  ns [3], ms [3], bs [3];
  logic signed [EXP_W-1:0] en_e, em_e, eb_e;

  logic signed [SV_W-1:0]   sel [3];
  logic signed [SQ_W-1:0]   sqa_d [3], sqb_d [3];
  logic signed [DPW-1:0]    dp_d [3];
  logic [SQ_W-1:0]          sqa_q [3], sqb_q [3];
  logic signed [DPW-1:0]    dp_q [3];
  logic signed [EXP_W-1:0]  k_d, k6_q;
  logic                     par6_q, v6_q;

  logic [SQ_W-1:0]         sq_in [2];
  logic signed [DOT_W-1:0] dot_d;
  logic                    sq_valid;
  logic [LEN_W-1:0]        root [2];
  logic [SIDE_W-1:0]       sq_side;
  logic signed [DOT_W-1:0] dot_r;
  logic signed [EXP_W-1:0] k_r;
  logic                    par_r;

  lld_ctl_t          ctl_d, ctl_r;
  logic [DIV_W-1:0]  num_d, den_d;
  logic [CTL_W-1:0]  dv_side;
  logic              dv_valid, dv_ovf;
  logic [CW-1:0]     quo;

  logic                 out_valid_q;
  logic signed [CW-1:0] dist_d, dist_q;
  logic                 par_q, fault_d, fault_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_W'(TOL_RESET);
    end else if (cfg_valid_i) begin
      tol_q <= cfg_near_zero_tolerance_i;
    end
  end

  assign a_d = '{dir_a_x_i, dir_a_y_i, dir_a_z_i};
  assign b_d = '{dir_b_x_i, dir_b_y_i, dir_b_z_i};
  assign w_d = '{joint_x_i, joint_y_i, joint_z_i};

  always_comb begin
    par_d = (n2_q[0] == '0) && (n2_q[1] == '0) && (n2_q[2] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v6_q <= 1'b0;
      for (int s = 0; s < 3; s++) v_sc_q[s] <= 1'b0;
    end else if (en) begin
      v1_q      <= in_valid_i;
      v2_q      <= v1_q;
      v_sc_q[0] <= v2_q;
      v_sc_q[1] <= v_sc_q[0];
      v_sc_q[2] <= v_sc_q[1];
      v6_q      <= v_sc_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pn_q[0] <= a_d[1] * b_d[2];
      pn_q[1] <= a_d[2] * b_d[1];
      pn_q[2] <= a_d[2] * b_d[0];
      pn_q[3] <= a_d[0] * b_d[2];
      pn_q[4] <= a_d[0] * b_d[1];
      pn_q[5] <= a_d[1] * b_d[0];
      pm_q[0] <= b_d[1] * w_d[2];
      pm_q[1] <= b_d[2] * w_d[1];
      pm_q[2] <= b_d[2] * w_d[0];
      pm_q[3] <= b_d[0] * w_d[2];
      pm_q[4] <= b_d[0] * w_d[1];
      pm_q[5] <= b_d[1] * w_d[0];
      b1_q    <= b_d;
      w1_q    <= w_d;
      for (int i = 0; i < 3; i++) begin
        n2_q[i] <= cross_snap(pn_q[2*i], pn_q[2*i+1], tol_q);
        m2_q[i] <= cross_snap(pm_q[2*i], pm_q[2*i+1], tol_q);
      end
      b2_q        <= b1_q;
      w2_q        <= w1_q;
      par_sc_q[0] <= par_d;
      par_sc_q[1] <= par_sc_q[0];
      par_sc_q[2] <= par_sc_q[1];
      w_sc_q[0]   <= w2_q;
      w_sc_q[1]   <= w_sc_q[0];
      w_sc_q[2]   <= w_sc_q[1];
    end
  end

  lld_scale #(.IN_W(XW)) u_lld_scale_n (
    .clk_i (clk_i),
    .en_i  (en),
    .c_i   (n2_q),
    .o_o   (ns),
    .e_o   (en_e)
  );

  lld_scale #(.IN_W(XW)) u_lld_scale_m (
    .clk_i (clk_i),
    .en_i  (en),
    .c_i   (m2_q),
    .o_o   (ms),
    .e_o   (em_e)
  );

  lld_scale #(.IN_W(CW)) u_lld_scale_b (
    .clk_i (clk_i),
    .en_i  (en),
    .c_i   (b2_q),
    .o_o   (bs),
    .e_o   (eb_e)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sel[i]   = par_sc_q[2] ? ms[i] : ns[i];
      sqa_d[i] = sel[i] * sel[i];
      sqb_d[i] = bs[i] * bs[i];
      dp_d[i]  = w_sc_q[2][i] * ns[i];
    end
    k_d = par_sc_q[2] ? EXP_W'(FRAC_BITS + int'(eb_e) - int'(em_e)) : en_e;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqa_q[i] <= SQ_W'(sqa_d[i]);
        sqb_q[i] <= SQ_W'(sqb_d[i]);
      end
      dp_q   <= dp_d;
      k6_q   <= k_d;
      par6_q <= par_sc_q[2];
    end
  end

  assign sq_in[0] = sqa_q[0] + sqa_q[1] + sqa_q[2];
  assign sq_in[1] = sqb_q[0] + sqb_q[1] + sqb_q[2];
  assign dot_d    = DOT_W'(dp_q[0]) + DOT_W'(dp_q[1]) + DOT_W'(dp_q[2]);

  lld_isqrt #(.SIDE_W(SIDE_W)) u_lld_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .x_i     (sq_in),
    .side_i  ({dot_d, k6_q, par6_q}),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  assign dot_r = sq_side[SIDE_W-1 -: DOT_W];
  assign k_r   = sq_side[EXP_W:1];
  assign par_r = sq_side[0];

  always_comb begin
    ctl_d.mode = MODE_DIV;
    ctl_d.neg  = 1'b0;
    ctl_d.par  = par_r;
    num_d      = '0;
    den_d      = '0;
    if (!par_r) begin
      ctl_d.neg = dot_r[DOT_W-1];
      num_d     = dot_r[DOT_W-1] ? DIV_W'(-dot_r) : DIV_W'(dot_r);
      den_d     = DIV_W'(root[0]);
      if (root[0] == '0) ctl_d.mode = MODE_SAT;
    end else if (root[1] == '0) begin
      ctl_d.mode = MODE_SAT;
    end else if (root[0] == '0) begin
      ctl_d.mode = MODE_ZERO;
    end else if (k_r > SHIFT_LIM) begin
      ctl_d.mode = MODE_SAT;
    end else if (k_r >= 0) begin
      num_d = DIV_W'(root[0]) << k_r;
      den_d = DIV_W'(root[1]);
    end else if (k_r >= -SHIFT_LIM) begin
      num_d = DIV_W'(root[0]);
      den_d = DIV_W'(root[1]) << (-k_r);
    end else begin
      ctl_d.mode = MODE_ZERO;
    end
  end

  lld_div #(.QW(CW), .SIDE_W(CTL_W)) u_lld_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .num_i   (num_d),
    .den_i   (den_d),
    .side_i  (ctl_d),
    .valid_o (dv_valid),
    .quo_o   (quo),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side)
  );

  assign ctl_r = lld_ctl_t'(dv_side);

  always_comb begin
    dist_d  = '0;
    fault_d = 1'b0;
    case (ctl_r.mode)
      MODE_SAT: begin
        dist_d  = MAXV;
        fault_d = 1'b1;
      end
      MODE_ZERO: begin
        dist_d = '0;
      end
      MODE_DIV: begin
        if (dv_ovf) begin
          dist_d  = ctl_r.neg ? MINV : MAXV;
          fault_d = 1'b1;
        end else if (ctl_r.neg) begin
          if (quo[CW-1] && (|quo[CW-2:0])) begin
            dist_d  = MINV;
            fault_d = 1'b1;
          end else begin
            dist_d = -$signed(quo);
          end
        end else if (quo[CW-1]) begin
          dist_d  = MAXV;
          fault_d = 1'b1;
        end else begin
          dist_d = $signed(quo);
        end
      end
      default: begin
        dist_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q  <= dist_d;
      par_q   <= ctl_r.par;
      fault_q <= fault_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distance_o       = dist_q;
  assign lines_parallel_o = par_q;
  assign fault_o          = fault_q;
endmodule
`default_nettype wire

// ----- src/lld_checker.sv -----
// Port-level checker for the 3D line distance unit and its bind.
`default_nettype none
`include "line_to_line_distance_3d_unit_macros.svh"
module lld_checker import lld_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [COORD_WIDTH-1:0] distance_o,
  input logic                   lines_parallel_o,
  input logic                   fault_o
);
  `LLD_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(distance_o) && $stable(fault_o) && $stable(lines_parallel_o), "result word changed under stall")
  `LLD_ASSERT_IMP(a_ready_when_empty, !out_valid_o, in_ready_o, "input stalled with empty output")
  `LLD_ASSERT_IMP(a_par_nonneg, out_valid_o && lines_parallel_o, !distance_o[COORD_WIDTH-1], "negative distance for parallel lines")
  `LLD_ASSERT_IMP(a_par_fault_max, out_valid_o && lines_parallel_o && fault_o, &distance_o[COORD_WIDTH-2:0], "parallel fault without positive saturation")
endmodule

bind line_to_line_distance_3d_unit lld_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lld_checker (.*);
`default_nettype wire
